[design/door_drive_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// door_drive_sequencer_defines.svh
// assertion helpers used by the door drive sequencer top level
// ----------------------------------------------------------------------------
`ifndef DOOR_DRIVE_SEQUENCER_DEFINES_SVH
`define DOOR_DRIVE_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define DDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("door drive sequencer check failed");

// next-cycle implication, held off while reset is low
`define DDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("door drive sequencer check failed");

`endif

[design/dds_pkg.sv]
// ----------------------------------------------------------------------------
// dds_pkg
// types and constants of the door drive sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETTLE   = 3'd1,
        PH_WAIT_PG  = 3'd2,
        PH_POWERUP  = 3'd3,
        PH_FIRE     = 3'd4,
        PH_TRACK    = 3'd5,
        PH_FINISH   = 3'd6,
        PH_DISABLE  = 3'd7
    } t_phase;

    // fault codes reported on a tick
    typedef enum logic [1:0] {
        FAULT_NONE        = 2'd0,
        FAULT_NO_RESPONSE = 2'd1,
        FAULT_NO_END      = 2'd2
    } t_fault;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SIMUL_MODE   = 3'd0,
        CFG_BOOST_SETTLE = 3'd1,
        CFG_POWERUP      = 3'd2,
        CFG_RESP_TIMEOUT = 3'd3,
        CFG_TRAVEL_TIMEOUT = 3'd4,
        CFG_FINISH       = 3'd5,
        CFG_DEBOUNCE     = 3'd6,
        CFG_LIGHT_HOLD   = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [15:0] RST_BOOST_SETTLE   = 16'd250;
    localparam logic [15:0] RST_POWERUP        = 16'd2000;
    localparam logic [15:0] RST_RESP_TIMEOUT   = 16'd2500;
    localparam logic [15:0] RST_TRAVEL_TIMEOUT = 16'd60000;
    localparam logic [15:0] RST_FINISH         = 16'd5000;
    localparam logic [15:0] RST_DEBOUNCE       = 16'd400;
    localparam logic [15:0] RST_LIGHT_HOLD     = 16'd30000;

    // motor direction codes
    localparam logic [1:0] DIR_STOPPED = 2'd0;
    localparam logic [1:0] DIR_UP      = 2'd1;

    // light state bits: bit 0 light on, bit 1 hold counting
    localparam logic [1:0] LIGHT_OFF     = 2'b00;
    localparam logic [1:0] LIGHT_ON      = 2'b01;
    localparam logic [1:0] LIGHT_HOLDING = 2'b11;

    typedef struct packed {
        logic        simul_mode;
        logic [15:0] boost_settle;
        logic [15:0] powerup;
        logic [15:0] resp_timeout;
        logic [15:0] travel_timeout;
        logic [15:0] finish;
        logic [15:0] debounce;
        logic [15:0] light_hold;
    } t_cfg;

    // input beat, first member lands in the top bits
    typedef struct packed {
        logic [1:0] motor_dir;
        logic       boost_good;
        logic       front_button;
        logic       radio_two;
        logic       key_two;
        logic       radio_one;
        logic       key_one;
    } t_item;

    // result beat
    typedef struct packed {
        t_phase phase_now;
        t_fault fault;
        logic   door_is_up;
        logic   light_on;
        logic   pulse_two;
        logic   pulse_one;
        logic   output_enable;
        logic   boost_enable;
    } t_result;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned RESULT_W   = $bits(t_result);

endpackage

`default_nettype wire

[design/door_drive_sequencer.sv]
// ----------------------------------------------------------------------------
// door_drive_sequencer
// door opener power and trigger sequencer, one beat per millisecond tick
// ----------------------------------------------------------------------------
// channel   direction  width  contents
// s_axis    in         8      sampled buttons, boost good, motor direction
// m_axis    out        16     drives, pulses, light, fault, phase
// cfg       in         3+16   register write, index and data
//
// one beat per clock cycle sustained while the output accepts; a beat waits
// in the input register and its result is loaded into the output register
// the rate is set by the sequencer state update, which runs once per beat
// reset is synchronous and active low; it restores all state but the beat payloads
// a stalled output holds its result while one more input beat may wait
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "door_drive_sequencer_defines.svh"

module door_drive_sequencer #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // key_one, radio_one, key_two, radio_two, front_button, boost_good, motor_dir[1:0]
    input  wire logic [dds_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // boost_enable, output_enable, pulse_one, pulse_two, light_on, door_is_up,
    // fault[1:0], phase_now[2:0], zero fill
    output logic [dds_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic                           i_cfg_we,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [dds_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dds_pkg::t_cfg    w_cfg;
    dds_pkg::t_item   r_in;
    dds_pkg::t_result r_out;
    dds_pkg::t_result w_result;
    logic             r_in_valid, n_in_valid;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free, w_step, w_in_acc;

    dds_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dds_seq_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // handshake between input register, core and output register
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_step;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // beat payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_in <= dds_pkg::t_item'(i_s_axis_tdata);
        if (w_step)   r_out <= w_result;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(dds_pkg::OUT_DATA_W - dds_pkg::RESULT_W){1'b0}}, r_out};

    // checks
    `DDS_ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !w_step, r_in_valid)
    `DDS_ASSERT_NOW(a_oe_needs_boost, i_clk, i_rst_n,
        r_out_valid && r_out.output_enable, r_out.boost_enable)
    // a retry can coincide with the stop being confirmed, so finish is allowed too
    `DDS_ASSERT_NOW(a_pulse_in_track, i_clk, i_rst_n,
        r_out_valid && (r_out.pulse_one || r_out.pulse_two),
        r_out.phase_now == dds_pkg::PH_TRACK || r_out.phase_now == dds_pkg::PH_FINISH)
    `DDS_ASSERT_NOW(a_fault_to_finish, i_clk, i_rst_n,
        r_out_valid && (r_out.fault != dds_pkg::FAULT_NONE),
        r_out.phase_now == dds_pkg::PH_FINISH)

endmodule

`default_nettype wire

[design/dds_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dds_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [dds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dds_pkg::t_cfg                       o_cfg
);

    dds_pkg::t_cfg r_cfg;
    dds_pkg::t_cfg n_cfg;

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (dds_pkg::t_cfg_idx'(i_cfg_index))
                dds_pkg::CFG_SIMUL_MODE:     n_cfg.simul_mode     = i_cfg_data[0];
                dds_pkg::CFG_BOOST_SETTLE:   n_cfg.boost_settle   = i_cfg_data;
                dds_pkg::CFG_POWERUP:        n_cfg.powerup        = i_cfg_data;
                dds_pkg::CFG_RESP_TIMEOUT:   n_cfg.resp_timeout   = i_cfg_data;
                dds_pkg::CFG_TRAVEL_TIMEOUT: n_cfg.travel_timeout = i_cfg_data;
                dds_pkg::CFG_FINISH:         n_cfg.finish         = i_cfg_data;
                dds_pkg::CFG_DEBOUNCE:       n_cfg.debounce       = i_cfg_data;
                dds_pkg::CFG_LIGHT_HOLD:     n_cfg.light_hold     = i_cfg_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.simul_mode     <= 1'b0;
            r_cfg.boost_settle   <= dds_pkg::RST_BOOST_SETTLE;
            r_cfg.powerup        <= dds_pkg::RST_POWERUP;
            r_cfg.resp_timeout   <= dds_pkg::RST_RESP_TIMEOUT;
            r_cfg.travel_timeout <= dds_pkg::RST_TRAVEL_TIMEOUT;
            r_cfg.finish         <= dds_pkg::RST_FINISH;
            r_cfg.debounce       <= dds_pkg::RST_DEBOUNCE;
            r_cfg.light_hold     <= dds_pkg::RST_LIGHT_HOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[design/dds_seq_core.sv]
// ----------------------------------------------------------------------------
// dds_seq_core
// sequencer state, timers and per-tick next-state logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_seq_core #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire dds_pkg::t_item i_item,
    input  wire dds_pkg::t_cfg  i_cfg,
    output dds_pkg::t_result    o_result
);

    localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // state registers
    dds_pkg::t_phase       r_phase;
    logic [TIMER_BITS-1:0] r_stage, r_resp, r_travel, r_present, r_absent, r_light_cnt;
    logic                  r_resp_run, r_travel_run, r_retry, r_up;
    logic [1:0]            r_deb, r_fire, r_pending, r_light;

    dds_pkg::t_phase       n_phase;
    logic [TIMER_BITS-1:0] n_stage, n_resp, n_travel, n_present, n_absent, n_light_cnt;
    logic                  n_resp_run, n_travel_run, n_retry, n_up;
    logic [1:0]            n_deb, n_fire, n_pending, n_light;

    logic [1:0]            w_want;
    logic [1:0]            w_pulses;
    dds_pkg::t_fault       w_fault;
    logic                  w_present_done;

    // saturating tick count
    function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] c);
        bump = (&c) ? c : c + 1'b1;
    endfunction

    // timer done test, count against a 16-bit limit
    function automatic logic reached(input logic [TIMER_BITS-1:0] c, input logic [15:0] lim);
        logic [CMP_W-1:0] cw;
        logic [CMP_W-1:0] lw;
        cw = CMP_W'(c);
        lw = CMP_W'(lim);
        reached = (cw >= lw);
    endfunction

    assign w_want = {i_item.key_two | i_item.radio_two,
                     i_item.key_one | i_item.radio_one | i_item.front_button};

    // one tick of the sequencer
    always_comb begin
        n_phase      = r_phase;
        n_stage      = bump(r_stage);
        n_resp       = bump(r_resp);
        n_travel     = bump(r_travel);
        n_present    = bump(r_present);
        n_absent     = bump(r_absent);
        n_light_cnt  = bump(r_light_cnt);
        n_resp_run   = r_resp_run;
        n_travel_run = r_travel_run;
        n_retry      = r_retry;
        n_up         = r_up;
        n_deb        = r_deb;
        n_fire       = r_fire;
        n_pending    = r_pending;
        n_light      = r_light;
        w_pulses     = 2'b00;
        w_fault      = dds_pkg::FAULT_NONE;
        w_present_done = 1'b0;

        case (r_phase)
            dds_pkg::PH_IDLE: begin
                if (|w_want) begin
                    n_light = dds_pkg::LIGHT_ON;
                    n_fire  = i_cfg.simul_mode ? w_want : 2'b01;
                    n_retry = 1'b0;
                    n_stage = '0;
                    n_phase = dds_pkg::PH_SETTLE;
                end
            end
            dds_pkg::PH_SETTLE: begin
                if (reached(n_stage, i_cfg.boost_settle)) n_phase = dds_pkg::PH_WAIT_PG;
            end
            dds_pkg::PH_WAIT_PG: begin
                if (i_item.boost_good) begin
                    n_stage = '0;
                    n_phase = dds_pkg::PH_POWERUP;
                end
            end
            dds_pkg::PH_POWERUP: begin
                if (reached(n_stage, i_cfg.powerup)) n_phase = dds_pkg::PH_FIRE;
            end
            dds_pkg::PH_FIRE: begin
                w_pulses   = r_fire;
                n_resp     = '0;
                n_resp_run = 1'b1;
                n_deb      = 2'b00;
                n_phase    = dds_pkg::PH_TRACK;
            end
            dds_pkg::PH_TRACK: begin
                if (i_item.motor_dir != dds_pkg::DIR_STOPPED) begin
                    // motion seen: start debounce, confirm after the debounce time
                    n_resp_run = 1'b0;
                    if (!n_deb[0]) begin
                        n_present = '0;
                        n_deb[0]  = 1'b1;
                    end
                    if (reached(n_present, i_cfg.debounce)) begin
                        n_up = (i_item.motor_dir == dds_pkg::DIR_UP);
                        if (!n_travel_run) begin
                            n_travel     = '0;
                            n_travel_run = 1'b1;
                        end
                        n_deb[1] = 1'b0;
                    end
                end else begin
                    // no motion: drop an unconfirmed start, debounce the stop
                    w_present_done = n_deb[0] && reached(n_present, i_cfg.debounce);
                    if (n_deb[0] && !w_present_done) n_deb[0] = 1'b0;
                    if (n_travel_run) begin
                        if (!n_deb[1]) begin
                            n_absent = '0;
                            n_deb[1] = 1'b1;
                        end
                        if (reached(n_absent, i_cfg.debounce)) begin
                            n_travel_run = 1'b0;
                            n_stage      = '0;
                            n_phase      = dds_pkg::PH_FINISH;
                        end
                    end
                    // silent motor: one retry, then a fault
                    if (n_resp_run && reached(n_resp, i_cfg.resp_timeout) && !n_travel_run) begin
                        if (!n_retry) begin
                            n_retry  = 1'b1;
                            w_pulses = r_fire;
                            n_resp   = '0;
                        end else begin
                            w_fault = dds_pkg::FAULT_NO_RESPONSE;
                            n_stage = '0;
                            n_phase = dds_pkg::PH_FINISH;
                        end
                    end
                end
                // end-of-travel timeout
                if (n_travel_run && reached(n_travel, i_cfg.travel_timeout)) begin
                    w_fault = dds_pkg::FAULT_NO_END;
                    n_stage = '0;
                    n_phase = dds_pkg::PH_FINISH;
                end
                // latch requests for replay
                if (|w_want) begin
                    n_pending = i_cfg.simul_mode ? (n_pending | w_want) : 2'b01;
                end
            end
            dds_pkg::PH_FINISH: begin
                if (reached(n_stage, i_cfg.finish)) begin
                    if (|n_pending) begin
                        n_fire    = n_pending;
                        n_pending = 2'b00;
                        n_retry   = 1'b0;
                        n_light   = n_light & dds_pkg::LIGHT_ON;
                        n_phase   = dds_pkg::PH_FIRE;
                    end else begin
                        if (n_light == dds_pkg::LIGHT_ON) begin
                            n_light     = dds_pkg::LIGHT_HOLDING;
                            n_light_cnt = '0;
                        end
                        n_phase = dds_pkg::PH_DISABLE;
                    end
                end
            end
            default: begin
                n_resp_run   = 1'b0;
                n_travel_run = 1'b0;
                n_deb        = 2'b00;
                n_phase      = dds_pkg::PH_IDLE;
            end
        endcase

        // light hold expiry
        if (n_light == dds_pkg::LIGHT_HOLDING && reached(n_light_cnt, i_cfg.light_hold)) begin
            n_light = dds_pkg::LIGHT_OFF;
        end
    end

    // result of this tick
    always_comb begin
        o_result.phase_now     = n_phase;
        o_result.fault         = w_fault;
        o_result.door_is_up    = n_up;
        o_result.light_on      = n_light[0];
        o_result.pulse_two     = w_pulses[1];
        o_result.pulse_one     = w_pulses[0];
        o_result.output_enable = (n_phase >= dds_pkg::PH_POWERUP);
        o_result.boost_enable  = (n_phase != dds_pkg::PH_IDLE);
    end

    // state update, one tick per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dds_pkg::PH_IDLE;
            r_stage      <= '0;
            r_resp       <= '0;
            r_travel     <= '0;
            r_present    <= '0;
            r_absent     <= '0;
            r_light_cnt  <= '0;
            r_resp_run   <= 1'b0;
            r_travel_run <= 1'b0;
            r_retry      <= 1'b0;
            r_up         <= 1'b0;
            r_deb        <= 2'b00;
            r_fire       <= 2'b00;
            r_pending    <= 2'b00;
            r_light      <= dds_pkg::LIGHT_OFF;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_resp       <= n_resp;
            r_travel     <= n_travel;
            r_present    <= n_present;
            r_absent     <= n_absent;
            r_light_cnt  <= n_light_cnt;
            r_resp_run   <= n_resp_run;
            r_travel_run <= n_travel_run;
            r_retry      <= n_retry;
            r_up         <= n_up;
            r_deb        <= n_deb;
            r_fire       <= n_fire;
            r_pending    <= n_pending;
            r_light      <= n_light;
        end
    end

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the door drive sequencer: each accepted tick beat
// is run through a cycle model of the sequencer and the predicted result beat
// is compared field by field with what the block returns, over several
// register settings and with random gaps on both stream sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import dds_pkg::*;

// motor direction codes with no name in the package
localparam logic [1:0] DIR_DOWN = 2'd2;
localparam logic [1:0] DIR_ODD  = 2'd3;

// tick model and store of expected result beats
class door_tick_scoreboard;
    t_cfg        regs;
    t_phase      seq_phase;
    logic [15:0] stage_ticks, resp_ticks, travel_ticks;
    logic [15:0] seen_ticks, gone_ticks, lamp_ticks;
    logic        resp_armed, travel_armed, retried, went_up;
    logic [1:0]  debounce_armed, fire_mask, queued_mask, lamp;
    t_result     expected_ticks[$];
    int          errors;
    int          checked;

    function new();
        regs.simul_mode     = 1'b0;
        regs.boost_settle   = RST_BOOST_SETTLE;
        regs.powerup        = RST_POWERUP;
        regs.resp_timeout   = RST_RESP_TIMEOUT;
        regs.travel_timeout = RST_TRAVEL_TIMEOUT;
        regs.finish         = RST_FINISH;
        regs.debounce       = RST_DEBOUNCE;
        regs.light_hold     = RST_LIGHT_HOLD;
        seq_phase      = PH_IDLE;
        stage_ticks    = '0;
        resp_ticks     = '0;
        travel_ticks   = '0;
        seen_ticks     = '0;
        gone_ticks     = '0;
        lamp_ticks     = '0;
        resp_armed     = 1'b0;
        travel_armed   = 1'b0;
        retried        = 1'b0;
        went_up        = 1'b0;
        debounce_armed = '0;
        fire_mask      = '0;
        queued_mask    = '0;
        lamp           = LIGHT_OFF;
        errors         = 0;
        checked        = 0;
    endfunction

    // timers stick at all ones
    static function logic [15:0] sat_inc(logic [15:0] c);
        return (c == '1) ? c : c + 16'd1;
    endfunction

    // advance the sequencer by one accepted tick and queue its result
    function void accept_tick(t_item it);
        logic [1:0] asked;
        logic [1:0] fired;
        logic       has_req;
        t_fault     flt;
        t_result    r;
        asked = '0;
        fired = '0;
        flt   = FAULT_NONE;
        if (it.key_one | it.radio_one | it.front_button) asked[0] = 1'b1;
        if (it.key_two | it.radio_two) asked[1] = 1'b1;
        has_req = |asked;

        stage_ticks  = sat_inc(stage_ticks);
        resp_ticks   = sat_inc(resp_ticks);
        travel_ticks = sat_inc(travel_ticks);
        seen_ticks   = sat_inc(seen_ticks);
        gone_ticks   = sat_inc(gone_ticks);
        lamp_ticks   = sat_inc(lamp_ticks);

        case (seq_phase)
            PH_IDLE: begin
                if (has_req) begin
                    lamp        = LIGHT_ON;
                    fire_mask   = regs.simul_mode ? asked : 2'b01;
                    retried     = 1'b0;
                    stage_ticks = '0;
                    seq_phase   = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (stage_ticks >= regs.boost_settle) seq_phase = PH_WAIT_PG;
            end
            PH_WAIT_PG: begin
                if (it.boost_good) begin
                    stage_ticks = '0;
                    seq_phase   = PH_POWERUP;
                end
            end
            PH_POWERUP: begin
                if (stage_ticks >= regs.powerup) seq_phase = PH_FIRE;
            end
            PH_FIRE: begin
                fired          = fire_mask;
                resp_ticks     = '0;
                resp_armed     = 1'b1;
                debounce_armed = '0;
                seq_phase      = PH_TRACK;
            end
            PH_TRACK: begin
                if (it.motor_dir != DIR_STOPPED) begin
                    // motion seen: start or keep the presence debounce
                    resp_armed = 1'b0;
                    if (!debounce_armed[0]) begin
                        seen_ticks        = '0;
                        debounce_armed[0] = 1'b1;
                    end
                    if (seen_ticks >= regs.debounce) begin
                        went_up = (it.motor_dir == DIR_UP);
                        if (!travel_armed) begin
                            travel_ticks = '0;
                            travel_armed = 1'b1;
                        end
                        debounce_armed[1] = 1'b0;
                    end
                end else begin
                    // a short burst of motion is forgotten
                    if (debounce_armed[0] && !(seen_ticks >= regs.debounce))
                        debounce_armed[0] = 1'b0;
                    if (travel_armed) begin
                        if (!debounce_armed[1]) begin
                            gone_ticks        = '0;
                            debounce_armed[1] = 1'b1;
                        end
                        if (gone_ticks >= regs.debounce) begin
                            travel_armed = 1'b0;
                            stage_ticks  = '0;
                            seq_phase    = PH_FINISH;
                        end
                    end
                    // silent motor: one retry, then a fault
                    if (resp_armed && resp_ticks >= regs.resp_timeout && !travel_armed) begin
                        if (!retried) begin
                            retried    = 1'b1;
                            fired      = fire_mask;
                            resp_ticks = '0;
                        end else begin
                            flt         = FAULT_NO_RESPONSE;
                            stage_ticks = '0;
                            seq_phase   = PH_FINISH;
                        end
                    end
                end
                if (travel_armed && travel_ticks >= regs.travel_timeout) begin
                    flt         = FAULT_NO_END;
                    stage_ticks = '0;
                    seq_phase   = PH_FINISH;
                end
                // requests during motion are kept for a replay
                if (has_req) queued_mask = regs.simul_mode ? (queued_mask | asked) : 2'b01;
            end
            PH_FINISH: begin
                if (stage_ticks >= regs.finish) begin
                    if (queued_mask != '0) begin
                        fire_mask   = queued_mask;
                        queued_mask = '0;
                        retried     = 1'b0;
                        lamp        = lamp & LIGHT_ON;
                        seq_phase   = PH_FIRE;
                    end else begin
                        if (lamp == LIGHT_ON) begin
                            lamp       = LIGHT_HOLDING;
                            lamp_ticks = '0;
                        end
                        seq_phase = PH_DISABLE;
                    end
                end
            end
            default: begin
                resp_armed     = 1'b0;
                travel_armed   = 1'b0;
                debounce_armed = '0;
                seq_phase      = PH_IDLE;
            end
        endcase

        if (lamp == LIGHT_HOLDING && lamp_ticks >= regs.light_hold) lamp = LIGHT_OFF;

        r.boost_enable  = (seq_phase != PH_IDLE);
        r.output_enable = (seq_phase >= PH_POWERUP);
        r.pulse_one     = fired[0];
        r.pulse_two     = fired[1];
        r.light_on      = lamp[0];
        r.door_is_up    = went_up;
        r.fault         = flt;
        r.phase_now     = seq_phase;
        expected_ticks.push_back(r);
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] beat);
        t_result got, want;
        string   why;
        got = t_result'(beat[RESULT_W-1:0]);
        if (expected_ticks.size() == 0) begin
            flag($sformatf("result beat %04h with nothing expected", beat));
            return;
        end
        want = expected_ticks.pop_front();
        why  = "";
        if (got.boost_enable  != want.boost_enable)  why = {why, " boost_enable"};
        if (got.output_enable != want.output_enable) why = {why, " output_enable"};
        if (got.pulse_one     != want.pulse_one)     why = {why, " pulse_one"};
        if (got.pulse_two     != want.pulse_two)     why = {why, " pulse_two"};
        if (got.light_on      != want.light_on)      why = {why, " light_on"};
        if (got.door_is_up    != want.door_is_up)    why = {why, " door_is_up"};
        if (got.fault         != want.fault)         why = {why, " fault"};
        if (got.phase_now     != want.phase_now)     why = {why, " phase_now"};
        if (beat[OUT_DATA_W-1:RESULT_W] != '0)       why = {why, " fill"};
        if (why != "")
            flag($sformatf("result %0d,%s: expected %03h got %04h",
                           checked, why, want, beat));
        checked++;
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    t_item                 s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_index = CFG_SIMUL_MODE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tvalid;

    door_tick_scoreboard sb = new();

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    bit   hold_go = 1'b0;
    logic rx_hold = 1'b0;
    int   cycles = 0;

    // motor run generator
    int         motor_left = 0;
    logic [1:0] motor_now = DIR_STOPPED;
    int         run_span = 4;
    int         still_span = 4;

    door_drive_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver readiness
    always @(posedge i_clk) begin
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (60) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // request bits low to high: key_one, radio_one, key_two, radio_two, front_button
    function automatic t_item pins(logic [4:0] req, logic bg, logic [1:0] dir);
        return t_item'({dir, bg, req});
    endfunction

    // next tick: motor runs of random length, phase-biased requests, rare random beats
    function t_item next_tick();
        int         r;
        int         chance;
        logic [4:0] req;
        if ($urandom_range(99) < 6) return t_item'(8'($urandom_range(255)));
        if (motor_left == 0) begin
            if (motor_now == DIR_STOPPED) begin
                r = $urandom_range(99);
                motor_now  = (r < 45) ? DIR_UP : (r < 90) ? DIR_DOWN : DIR_ODD;
                motor_left = $urandom_range(1, run_span);
            end else begin
                motor_now  = DIR_STOPPED;
                motor_left = $urandom_range(1, still_span);
            end
        end
        motor_left--;
        chance = (sb.seq_phase == PH_IDLE) ? 30 : (sb.seq_phase == PH_TRACK) ? 8 : 3;
        req = ($urandom_range(99) < chance) ? 5'($urandom_range(1, 31)) : 5'd0;
        return pins(req, $urandom_range(99) < 70, motor_now);
    endfunction

    // offer one tick beat until it is taken, then model it
    task automatic push_tick(input t_item it);
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge i_clk); while (!s_tready);
        sb.accept_tick(it);
    endtask

    task automatic sender_gap();
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_ticks.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // write all registers, one per cycle
    task automatic load_settings(input t_cfg c);
        t_cfg_idx idx;
        idx = CFG_SIMUL_MODE;
        do begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_SIMUL_MODE:     cfg_data <= {15'd0, c.simul_mode};
                CFG_BOOST_SETTLE:   cfg_data <= c.boost_settle;
                CFG_POWERUP:        cfg_data <= c.powerup;
                CFG_RESP_TIMEOUT:   cfg_data <= c.resp_timeout;
                CFG_TRAVEL_TIMEOUT: cfg_data <= c.travel_timeout;
                CFG_FINISH:         cfg_data <= c.finish;
                CFG_DEBOUNCE:       cfg_data <= c.debounce;
                default:            cfg_data <= c.light_hold;
            endcase
            @(posedge i_clk);
            idx = idx.next();
        end while (idx != CFG_SIMUL_MODE);
        cfg_we <= 1'b0;
        sb.regs = c;
    endtask

    initial begin
        t_cfg  cfg;
        t_item directed[$];
        int    count;
        int    mode;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short timings so a whole sequence fits in a few beats
        cfg = '{simul_mode: 1'b1, boost_settle: 16'd1, powerup: 16'd1,
                resp_timeout: 16'd2, travel_timeout: 16'd3, finish: 16'd1,
                debounce: 16'd1, light_hold: 16'd0};
        load_settings(cfg);

        // both-channel request, boost late, retry, motion with a latched
        // request, replay, silent motor fault, zero light hold, odd direction
        directed = '{
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00101, 1'b0, DIR_STOPPED),
            pins(5'b10000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_STOPPED),
            pins(5'b00000, 1'b1, DIR_STOPPED), pins(5'b00000, 1'b1, DIR_STOPPED),
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_STOPPED),
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_UP),
            pins(5'b00000, 1'b0, DIR_UP),      pins(5'b01000, 1'b0, DIR_DOWN),
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_STOPPED),
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_STOPPED),
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_STOPPED),
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_STOPPED),
            pins(5'b00000, 1'b0, DIR_STOPPED), pins(5'b00000, 1'b0, DIR_STOPPED),
            pins(5'b11111, 1'b1, DIR_ODD),     pins(5'b00010, 1'b1, DIR_ODD)
        };
        foreach (directed[k]) push_tick(directed[k]);
        drain();

        // random phases, each with its own settings; gaps and stalls vary by phase
        for (int p = 1; p <= 8; p++) begin
            case (p)
                1: cfg = '{simul_mode: 1'b1, boost_settle: 16'd2, powerup: 16'd3,
                           resp_timeout: 16'd6, travel_timeout: 16'd20, finish: 16'd4,
                           debounce: 16'd3, light_hold: 16'd10};
                2: cfg = '{simul_mode: 1'b0, boost_settle: 16'd1, powerup: 16'd1,
                           resp_timeout: 16'd1, travel_timeout: 16'd1, finish: 16'd1,
                           debounce: 16'd1, light_hold: 16'd0};
                3: cfg = '{simul_mode: 1'b1, boost_settle: 16'hFFFF, powerup: 16'hFFFF,
                           resp_timeout: 16'hFFFF, travel_timeout: 16'hFFFF,
                           finish: 16'hFFFF, debounce: 16'hFFFF, light_hold: 16'hFFFF};
                4: cfg = '{simul_mode: 1'b0, boost_settle: 16'd4, powerup: 16'd2,
                           resp_timeout: 16'd10, travel_timeout: 16'd40, finish: 16'd3,
                           debounce: 16'd5, light_hold: 16'd25};
                default: begin
                    cfg.simul_mode     = 1'($urandom_range(1));
                    cfg.boost_settle   = 16'($urandom_range(1, 6));
                    cfg.powerup        = 16'($urandom_range(1, 6));
                    cfg.resp_timeout   = 16'($urandom_range(1, 8));
                    cfg.travel_timeout = 16'($urandom_range(2, 30));
                    cfg.finish         = 16'($urandom_range(1, 6));
                    cfg.debounce       = 16'($urandom_range(1, 6));
                    cfg.light_hold     = 16'($urandom_range(0, 20));
                end
            endcase
            load_settings(cfg);

            run_span   = int'(cfg.travel_timeout) + 2 * int'(cfg.debounce) + 4;
            still_span = 2 * int'(cfg.resp_timeout) + 4;
            if (run_span > 80) run_span = 80;
            if (still_span > 60) still_span = 60;

            mode = p % 4;
            tx_idle_pct  = (mode == 1) ? 53 : (mode == 3) ? 13 : 0;
            rx_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 13 : 0;

            count = (p == 3) ? 40 : 150;
            for (int k = 0; k < count; k++) begin
                if (p == 4 && k == 30) hold_go = 1'b1;
                sender_gap();
                push_tick(next_tick());
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
